// ===== src/frs_pkg.sv =====
// Shared types and constants for the 2x FIR resampler.
package frs_pkg;

    localparam int COEF_INDEX_BITS = 6;
    localparam int MODE_BITS       = 2;
    localparam int STRIDE_BITS     = 4;
    localparam int POS_BITS        = 3;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int CFG_DATA_BITS   = 4;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE   = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STRIDE = 1'd1;

    // mode register codes; the unused code behaves as bypass
    localparam logic [MODE_BITS-1:0] MODE_BYPASS = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_INTERP = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_DECIM  = 2'd2;

    localparam logic [STRIDE_BITS-1:0] STRIDE_MIN = 4'd1;
    localparam logic [STRIDE_BITS-1:0] STRIDE_MAX = 4'd8;

    // tuser codes on the input side
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_LOAD   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_DRAIN,
        ST_PUSH
    } t_state;

    typedef enum logic [1:0] {
        KIND_BYPASS,
        KIND_INTERP,
        KIND_DECIM
    } t_kind;

    typedef struct packed {
        logic hist_shift;
        logic load_work;
        logic wshift_h;
        logic wshift_c;
    } t_cell_ctl;

endpackage

// ===== src/fir_resampler_2x.sv =====
// A bypassed sample goes from IDLE to PUSH; a filtered sample (interpolate, or decimate
// on the second kept sample) goes through LOAD, RUN, DRAIN and PUSH, using the one shared
// MAC that reads the tap cell chain one tap per cycle. A load, a skipped channel or the
// first of a decimated pair leaves the block in IDLE; the input is ready only in IDLE, so
// no item is taken while a sample is in work; a full output queue holds PUSH on tready.
// Reset (synchronous, active low) clears history, coefficients, mode, stride and
// channel position at once; there is no clearing pass.
module fir_resampler_2x #(
    parameter int TAPS        = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 18
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [frs_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [frs_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // sample_value, coef_index, coef_value, zero pad
    input  logic [((SAMPLE_BITS + frs_pkg::COEF_INDEX_BITS + COEF_BITS + 7) / 8) * 8 - 1:0]
                                                 s_axis_tdata,
    // action
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // out_sample, zero pad
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic                                 m_axis_tlast
);
    import frs_pkg::*;

    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CNT_W = $clog2(TAPS);

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;

    logic [MODE_BITS-1:0]   r_mode;
    logic [STRIDE_BITS-1:0] r_stride;
    logic [POS_BITS-1:0]    r_pos;
    logic                   r_phase;
    logic [CNT_W-1:0]       r_cnt;
    logic signed [SAMPLE_BITS-1:0] r_byp;

    logic signed [SAMPLE_BITS-1:0] r_q_data [2];
    logic                          r_q_last [2];
    logic [1:0]                    r_q_cnt;

    logic accept, in_load, in_samp, keep, start, push, pop, run_last;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic [COEF_INDEX_BITS-1:0]    in_coef_idx;
    logic signed [COEF_BITS-1:0]   in_coef;
    logic [STRIDE_BITS-1:0]        stride_eff;
    logic [STRIDE_BITS-1:0]        pos_inc;

    t_cell_ctl cell_ctl;
    logic      mac_clear, mac_issue, mac_tag;
    logic signed [SAMPLE_BITS-1:0] mac_even, mac_odd;

    logic signed [SAMPLE_BITS-1:0] w_hist   [TAPS];
    logic signed [SAMPLE_BITS-1:0] w_work_h [TAPS];
    logic signed [COEF_BITS-1:0]   w_work_c [TAPS];

    assign in_sample   = s_axis_tdata[SAMPLE_BITS-1:0];
    assign in_coef_idx = s_axis_tdata[SAMPLE_BITS +: COEF_INDEX_BITS];
    assign in_coef     = s_axis_tdata[SAMPLE_BITS + COEF_INDEX_BITS +: COEF_BITS];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_load       = accept && (s_axis_tuser == ACT_LOAD);
    assign in_samp       = accept && (s_axis_tuser == ACT_SAMPLE);
    assign keep          = in_samp && (r_pos == '0);

    assign stride_eff = (r_stride < STRIDE_MIN) ? STRIDE_MIN :
                        ((r_stride > STRIDE_MAX) ? STRIDE_MAX : r_stride);
    assign pos_inc    = STRIDE_BITS'(r_pos) + STRIDE_BITS'(1);
    assign run_last   = (r_cnt == CNT_W'(TAPS - 1));

    always_comb begin
        case (r_mode)
            MODE_INTERP: n_kind = KIND_INTERP;
            MODE_DECIM:  n_kind = KIND_DECIM;
            default:     n_kind = KIND_BYPASS;
        endcase
    end

    // the first of each pair of kept samples in decimate mode only advances the phase
    assign start = keep && ((n_kind == KIND_INTERP) || ((n_kind == KIND_DECIM) && r_phase));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_LOAD;
                end else if (keep && (n_kind == KIND_BYPASS)) begin
                    n_state = ST_PUSH;
                end
            end
            ST_LOAD:  n_state = ST_RUN;
            ST_RUN: begin
                if (run_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_PUSH;
            ST_PUSH: begin
                if (r_q_cnt == 2'd0) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        cell_ctl.hist_shift = keep;
        cell_ctl.load_work  = (r_state == ST_LOAD);
        cell_ctl.wshift_c   = (r_state == ST_RUN);
        // interpolation reuses each sample for an even and an odd tap
        cell_ctl.wshift_h   = (r_state == ST_RUN) && ((r_kind == KIND_DECIM) || r_cnt[0]);
        mac_clear           = (r_state == ST_LOAD);
        mac_issue           = (r_state == ST_RUN);
        mac_tag             = (r_kind == KIND_INTERP) && r_cnt[0];
        push                = (r_state == ST_PUSH) && (r_q_cnt == 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_kind   <= KIND_BYPASS;
            r_mode   <= MODE_BYPASS;
            r_stride <= STRIDE_MIN;
            r_pos    <= '0;
            r_phase  <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_MODE:   r_mode   <= i_cfg_data[MODE_BITS-1:0];
                    REG_STRIDE: r_stride <= i_cfg_data[STRIDE_BITS-1:0];
                    default: ;
                endcase
            end
            if (in_samp) begin
                r_pos <= (pos_inc >= stride_eff) ? '0 : pos_inc[POS_BITS-1:0];
            end
            if (keep) begin
                r_kind <= n_kind;
                if (n_kind == KIND_DECIM) begin
                    r_phase <= ~r_phase;
                end
            end
            if (r_state == ST_LOAD) begin
                r_cnt <= '0;
            end else if (r_state == ST_RUN) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (keep) begin
            r_byp <= in_sample;
        end
    end

    // two-entry output queue, filled only when empty
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = (r_q_cnt != 2'd0);
    assign m_axis_tdata  = OUT_W'($unsigned(r_q_data[0]));
    assign m_axis_tlast  = r_q_last[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= 2'd0;
        end else if (push) begin
            r_q_cnt <= (r_kind == KIND_INTERP) ? 2'd2 : 2'd1;
        end else if (pop) begin
            r_q_cnt <= r_q_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_data[0] <= (r_kind == KIND_BYPASS) ? r_byp : mac_even;
            r_q_last[0] <= (r_kind != KIND_INTERP);
            r_q_data[1] <= mac_odd;
            r_q_last[1] <= 1'b1;
        end else if (pop) begin
            r_q_data[0] <= r_q_data[1];
            r_q_last[0] <= r_q_last[1];
        end
    end

    for (genvar i = 0; i < TAPS; i++) begin : g_cell
        logic                          coef_we;
        logic signed [SAMPLE_BITS-1:0] hist_in;
        logic signed [SAMPLE_BITS-1:0] work_h_in;
        logic signed [COEF_BITS-1:0]   work_c_in;

        assign coef_we = in_load && (int'(in_coef_idx) == i);

        if (i == 0) begin : g_head
            assign hist_in = in_sample;
        end else begin : g_body
            assign hist_in = w_hist[i-1];
        end

        if (i == TAPS - 1) begin : g_tail
            assign work_h_in = '0;
            assign work_c_in = '0;
        end else begin : g_link
            assign work_h_in = w_work_h[i+1];
            assign work_c_in = w_work_c[i+1];
        end

        frs_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .COEF_BITS   (COEF_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (cell_ctl),
            .i_hist    (hist_in),
            .i_coef_we (coef_we),
            .i_coef    (in_coef),
            .i_work_h  (work_h_in),
            .i_work_c  (work_c_in),
            .o_hist    (w_hist[i]),
            .o_work_h  (w_work_h[i]),
            .o_work_c  (w_work_c[i])
        );
    end

    frs_mac #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (mac_clear),
        .i_issue (mac_issue),
        .i_tag   (mac_tag),
        .i_x     (w_work_h[0]),
        .i_c     (w_work_c[0]),
        .o_even  (mac_even),
        .o_odd   (mac_odd)
    );

endmodule

// ===== src/frs_cell.sv =====
// One tap cell: a history sample, a coefficient, and their working copies.
module frs_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 18
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  frs_pkg::t_cell_ctl            i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_hist,
    input  logic                          i_coef_we,
    input  logic signed [COEF_BITS-1:0]   i_coef,
    input  logic signed [SAMPLE_BITS-1:0] i_work_h,
    input  logic signed [COEF_BITS-1:0]   i_work_c,
    output logic signed [SAMPLE_BITS-1:0] o_hist,
    output logic signed [SAMPLE_BITS-1:0] o_work_h,
    output logic signed [COEF_BITS-1:0]   o_work_c
);
    import frs_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_hist;
    logic signed [COEF_BITS-1:0]   r_coef;
    logic signed [SAMPLE_BITS-1:0] r_work_h;
    logic signed [COEF_BITS-1:0]   r_work_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_coef <= '0;
        end else begin
            if (i_ctl.hist_shift) begin
                r_hist <= i_hist;
            end
            if (i_coef_we) begin
                r_coef <= i_coef;
            end
        end
    end

    // working copies walk toward cell 0, where the MAC reads them
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_work) begin
            r_work_h <= r_hist;
            r_work_c <= r_coef;
        end else begin
            if (i_ctl.wshift_h) begin
                r_work_h <= i_work_h;
            end
            if (i_ctl.wshift_c) begin
                r_work_c <= i_work_c;
            end
        end
    end

    assign o_hist   = r_hist;
    assign o_work_h = r_work_h;
    assign o_work_c = r_work_c;

endmodule

// ===== src/frs_mac.sv =====
// Shared multiply-accumulate with even and odd accumulators and round/saturate.
module frs_mac #(
    parameter int TAPS        = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 18
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_issue,
    input  logic                          i_tag,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [COEF_BITS-1:0]   i_c,
    output logic signed [SAMPLE_BITS-1:0] o_even,
    output logic signed [SAMPLE_BITS-1:0] o_odd
);
    import frs_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + $clog2(TAPS) + 1;
    localparam logic signed [ACC_W-1:0] RND     = ACC_W'(64'd1 << (COEF_BITS - 2));
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic                     r_ptag;
    logic signed [ACC_W-1:0]  r_acc_even;
    logic signed [ACC_W-1:0]  r_acc_odd;

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [ACC_W-1:0] a
    );
        logic signed [ACC_W-1:0] s;
        logic signed [ACC_W-1:0] q;
        s = a + RND;
        q = s >>> (COEF_BITS - 1);
        if (q > SAT_MAX) begin
            return SAT_MAX[SAMPLE_BITS-1:0];
        end else if (q < SAT_MIN) begin
            return SAT_MIN[SAMPLE_BITS-1:0];
        end
        return q[SAMPLE_BITS-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_x * i_c;
        r_ptag <= i_tag;
        if (i_clear) begin
            r_acc_even <= '0;
            r_acc_odd  <= '0;
        end else if (r_pv) begin
            if (r_ptag) begin
                r_acc_odd <= r_acc_odd + ACC_W'(r_prod);
            end else begin
                r_acc_even <= r_acc_even + ACC_W'(r_prod);
            end
        end
    end

    assign o_even = round_sat(r_acc_even);
    assign o_odd  = round_sat(r_acc_odd);

endmodule

// ===== src/frs_checker.sv =====
// Port-level checks for the 2x FIR resampler, bound to its top level.
module frs_checker #(
    parameter int OUT_W = 16
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             s_axis_tuser,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             m_axis_tlast
);
    import frs_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output transaction changed");

    // reset empties the output queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // a coefficient load never stalls the input
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_LOAD) |=> s_axis_tready)
        else $error("input stalled after a coefficient load");

    // the odd-phase result follows the even-phase one without a gap
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("second result of a pair missing");

endmodule

bind fir_resampler_2x frs_checker #(
    .OUT_W (OUT_W)
) u_frs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/fir_resampler_checker.sv =====
// Stream monitor for fir_resampler_2x: predicts each output sample and compares it.
module fir_resampler_checker #(
    parameter int TAPS        = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 18
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [frs_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [frs_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    // sample_value, coef_index, coef_value, zero pad
    input  logic [((SAMPLE_BITS + frs_pkg::COEF_INDEX_BITS + COEF_BITS + 7) / 8) * 8 - 1:0]
                                                i_s_tdata,
    // action
    input  logic                                i_s_tuser,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    // out_sample, zero pad
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] i_m_tdata,
    input  logic                                i_m_tlast,
    output int                                  o_n_pending,
    output int                                  o_n_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    import frs_pkg::*;

    localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam int     HALF_TAPS  = (TAPS + 1) / 2;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          last;
    } t_result;

    logic signed [COEF_BITS-1:0]   coef_mem [TAPS];
    logic signed [SAMPLE_BITS-1:0] history [TAPS];
    logic                          decim_odd;
    int                            chan_pos;
    logic [MODE_BITS-1:0]          mode_reg;
    logic [STRIDE_BITS-1:0]        stride_reg;
    t_result                       expected_samples [$];

    function automatic longint coef_at(input int k);
        if (k >= TAPS)
            return 0;
        return longint'(coef_mem[k]);
    endfunction

    // round half up at the coefficient point, then clamp to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] round_saturate(input longint acc);
        longint r;
        r = (acc + (longint'(1) <<< (COEF_BITS - 2))) >>> (COEF_BITS - 1);
        if (r > SAMPLE_MAX)
            r = SAMPLE_MAX;
        else if (r < SAMPLE_MIN)
            r = SAMPLE_MIN;
        return r[SAMPLE_BITS-1:0];
    endfunction

    task automatic push_result(input logic signed [SAMPLE_BITS-1:0] value, input logic last);
        t_result r;
        r.value = value;
        r.last  = last;
        expected_samples.push_back(r);
    endtask

    task automatic predict_filter(
        input logic                          act,
        input logic signed [SAMPLE_BITS-1:0] smp,
        input logic [COEF_INDEX_BITS-1:0]    idx,
        input logic signed [COEF_BITS-1:0]   coef
    );
        int     eff_stride;
        logic   keep;
        longint acc_even;
        longint acc_odd;

        if (act == ACT_LOAD) begin
            if (int'(idx) < TAPS)
                coef_mem[idx] = coef;
            return;
        end

        eff_stride = (stride_reg == 0) ? 1 : ((stride_reg > STRIDE_MAX) ? STRIDE_MAX : stride_reg);
        keep       = (chan_pos == 0);
        chan_pos   = (chan_pos + 1 >= eff_stride) ? 0 : chan_pos + 1;
        if (!keep)
            return;

        for (int i = TAPS - 1; i > 0; i--)
            history[i] = history[i-1];
        history[0] = smp;

        case (mode_reg)
            MODE_INTERP: begin
                acc_even = 0;
                acc_odd  = 0;
                for (int i = 0; i < HALF_TAPS; i++) begin
                    acc_even += coef_at(2 * i) * longint'(history[i]);
                    acc_odd  += coef_at(2 * i + 1) * longint'(history[i]);
                end
                push_result(round_saturate(acc_even), 1'b0);
                push_result(round_saturate(acc_odd), 1'b1);
            end
            MODE_DECIM: begin
                // only every second kept sample produces an output
                decim_odd = ~decim_odd;
                if (decim_odd)
                    return;
                acc_even = 0;
                for (int i = 0; i < TAPS; i++)
                    acc_even += coef_at(i) * longint'(history[i]);
                push_result(round_saturate(acc_even), 1'b1);
            end
            default: begin
                push_result(smp, 1'b1);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result                       exp_r;
        logic signed [SAMPLE_BITS-1:0] got;

        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                coef_mem[i] = '0;
                history[i]  = '0;
            end
            decim_odd  = 1'b0;
            chan_pos   = 0;
            mode_reg   = MODE_BYPASS;
            stride_reg = STRIDE_MIN;
            expected_samples.delete();
            o_n_errors = 0;
        end else begin
            // check outputs before predicting, so a same-cycle input cannot pair with them
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[SAMPLE_BITS-1:0];
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected output: expected none, actual %0d (tlast %0b)",
                             $time, got, i_m_tlast);
                    o_n_errors++;
                end else begin
                    exp_r = expected_samples.pop_front();
                    if (got !== exp_r.value) begin
                        $display("%0t: out_sample mismatch: expected %0d, actual %0d",
                                 $time, exp_r.value, got);
                        o_n_errors++;
                    end
                    if (i_m_tlast !== exp_r.last) begin
                        $display("%0t: tlast mismatch: expected %0b, actual %0b",
                                 $time, exp_r.last, i_m_tlast);
                        o_n_errors++;
                    end
                end
            end

            if (i_cfg_wr_en) begin
                if (i_cfg_index == REG_MODE)
                    mode_reg = i_cfg_data[MODE_BITS-1:0];
                else if (i_cfg_index == REG_STRIDE)
                    stride_reg = i_cfg_data[STRIDE_BITS-1:0];
            end

            if (i_s_tvalid && i_s_tready)
                predict_filter(i_s_tuser,
                               i_s_tdata[SAMPLE_BITS-1:0],
                               i_s_tdata[SAMPLE_BITS +: COEF_INDEX_BITS],
                               i_s_tdata[SAMPLE_BITS + COEF_INDEX_BITS +: COEF_BITS]);
        end
        o_n_pending = expected_samples.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// Top-level testbench for fir_resampler_2x: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import frs_pkg::*;

    localparam int TAPS          = 64;
    localparam int SAMPLE_BITS   = 16;
    localparam int COEF_BITS     = 18;
    localparam int TDATA_W       = ((SAMPLE_BITS + COEF_INDEX_BITS + COEF_BITS + 7) / 8) * 8;
    localparam int OUT_W         = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = TAPS + 16;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 58;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]   i_cfg_data = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [TDATA_W-1:0]         s_axis_tdata = '0;   // sample_value, coef_index, coef_value
    logic                       s_axis_tuser = 1'b0; // action
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_W-1:0]           m_axis_tdata;        // out_sample
    logic                       m_axis_tlast;

    int                         n_pending;
    int                         n_errors;
    bit                         rush = 1'b0;         // no idling on either side while set

    always #1 i_clk = ~i_clk;

    fir_resampler_2x #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    fir_resampler_checker #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tlast   (m_axis_tlast),
        .o_n_pending (n_pending),
        .o_n_errors  (n_errors)
    );

    // output side: a random stall before each transaction, none while rush is set
    initial begin
        int stall;
        wait (i_rst_n);
        forever begin
            stall = rush ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    task automatic send_item(
        input logic                          act,
        input logic signed [SAMPLE_BITS-1:0] smp,
        input logic [COEF_INDEX_BITS-1:0]    idx,
        input logic signed [COEF_BITS-1:0]   coef
    );
        int gap;
        gap = rush ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = {coef, idx, smp};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // unused fields carry random bits
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp);
        send_item(ACT_SAMPLE, smp, COEF_INDEX_BITS'($urandom), COEF_BITS'($urandom));
    endtask

    task automatic send_load(input logic [COEF_INDEX_BITS-1:0] idx,
                             input logic signed [COEF_BITS-1:0] coef);
        send_item(ACT_LOAD, SAMPLE_BITS'($urandom), idx, coef);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // half full-scale, half small taps so outputs do not all saturate
    function automatic logic signed [COEF_BITS-1:0] pick_coef();
        if ($urandom_range(0, 1) == 0)
            return COEF_BITS'($urandom);
        return COEF_BITS'($signed($urandom_range(0, 8191)) - 4096);
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // drain every expected output, then give the filter time to finish silent work
    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (n_pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [MODE_BITS-1:0]   mode_sel;
        logic [STRIDE_BITS-1:0] stride_sel;

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // bypass at reset settings: full-scale and sign-boundary samples, then load taps 0, 1, 2 and 63
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'shffff);
        send_load(6'd0, 18'sh20000);
        send_load(6'd1, 18'sh20000);
        send_load(6'd2, 18'sh1ffff);
        send_load(6'd63, 18'sh1ffff);
        settle();

        // most negative times most negative saturates high
        write_reg(REG_MODE, CFG_DATA_BITS'(MODE_INTERP));
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        settle();

        write_reg(REG_MODE, CFG_DATA_BITS'(MODE_DECIM));
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh3039);
        settle();

        // unused mode code and zero stride both fall back to defaults
        write_reg(REG_MODE, 4'b0011);
        write_reg(REG_STRIDE, 4'd0);
        send_sample(16'sh0001);
        settle();

        // stride three, then shrink the stride mid frame
        write_reg(REG_MODE, CFG_DATA_BITS'(MODE_BYPASS));
        write_reg(REG_STRIDE, 4'd3);
        repeat (4) send_sample(pick_sample());
        settle();
        write_reg(REG_STRIDE, STRIDE_MIN);
        repeat (2) send_sample(pick_sample());
        settle();

        write_reg(REG_STRIDE, 4'd15);
        repeat (2) send_sample(pick_sample());
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin mode_sel = MODE_INTERP; stride_sel = STRIDE_MIN; end
                1: begin mode_sel = MODE_DECIM;  stride_sel = STRIDE_MIN; end
                2: begin mode_sel = MODE_INTERP; stride_sel = 4'd2;       end
                3: begin mode_sel = MODE_DECIM;  stride_sel = STRIDE_MAX; end
                default: begin
                    mode_sel   = MODE_BITS'($urandom_range(0, 3));
                    stride_sel = ($urandom_range(0, 3) == 0) ? STRIDE_BITS'($urandom_range(0, 15))
                                                             : STRIDE_BITS'($urandom_range(1, 2));
                end
            endcase
            // upper data bits are don't-care for the mode register
            write_reg(REG_MODE, {2'($urandom_range(0, 3)), mode_sel});
            write_reg(REG_STRIDE, stride_sel);

            // fill the whole store once so the filters see real taps
            if (p == 0)
                for (int k = 0; k < TAPS; k++)
                    send_load(COEF_INDEX_BITS'(k), pick_coef());

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 20 == 0)
                    rush = ($urandom_range(0, 2) == 0);
                if ($urandom_range(0, 99) < 15)
                    send_load(COEF_INDEX_BITS'($urandom_range(0, TAPS - 1)), pick_coef());
                else
                    send_sample(pick_sample());
            end
            rush = 1'b0;
            settle();
        end

        if (n_errors == 0)
            $display("fir_resampler_2x regression: pass");
        else
            $display("fir_resampler_2x regression: fail");
        $finish;
    end

    initial begin
        #1_500_000;
        $display("fir_resampler_2x regression: fail");
        $finish;
    end

endmodule
